// File: hw/rtl/x86g3_pkg.sv
// x86g3_pkg: shared types and constants for the x86 group-3 mul/div unit
// no dependencies; imported by every module of the unit

package x86g3_pkg;

	localparam int WORD_W    = 16;
	localparam int DIV_STEPS = WORD_W;
	localparam int IN_DATA_W  = 64;
	localparam int IN_USER_W  = 4;
	localparam int OUT_DATA_W = 64;

	localparam logic [15:0] SIGN_WORD = 16'h8000;
	localparam logic [15:0] SIGN_BYTE = 16'h0080;
	localparam logic [15:0] MASK_WORD = 16'hFFFF;
	localparam logic [15:0] MASK_BYTE = 16'h00FF;

	typedef enum logic [2:0] {
		CMD_TEST   = 3'd0,
		CMD_UNUSED = 3'd1,
		CMD_NOT    = 3'd2,
		CMD_NEG    = 3'd3,
		CMD_MUL    = 3'd4,
		CMD_IMUL   = 3'd5,
		CMD_DIV    = 3'd6,
		CMD_IDIV   = 3'd7
	} cmd_t;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_BAD_CMD = 2'd1;
	localparam logic [1:0] ERR_DIVIDE  = 2'd2;

	localparam logic [1:0] GRP_NONE = 2'd0;
	localparam logic [1:0] GRP_CO   = 2'd1;
	localparam logic [1:0] GRP_COZS = 2'd2;
	localparam logic [1:0] GRP_ALL  = 2'd3;

	typedef struct packed {
		logic [15:0] acc;
		logic [15:0] ext;
		logic [15:0] opo;
		logic        opw;
		logic [1:0]  grp;
		logic        cf;
		logic        of;
		logic        zf;
		logic        sf;
		logic        pf;
		logic [1:0]  err;
	} res_t;

	typedef struct packed {
		cmd_t        cmd;
		logic        wide;
		res_t        res;
		logic [31:0] prod;
		logic        n_neg;
		logic        d_neg;
		logic        pre_ovf;
	} ctx_t;

	typedef struct packed {
		logic [31:0] w;
		logic [15:0] dmag;
	} divst_t;

endpackage

// File: hw/rtl/x86g3_front.sv
// x86g3_front: decode, test/not/neg, multiplier and divider setup stage
// depends on x86g3_pkg

module x86g3_front import x86g3_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  cmd_t        cmd,
	input  logic        wide,
	input  logic [15:0] operand,
	input  logic [15:0] immediate,
	input  logic [15:0] acc_in,
	input  logic [15:0] ext_in,
	output logic        out_valid,
	input  logic        out_ready,
	output ctx_t        out_ctx,
	output divst_t      out_div
);

	logic               valid_s1;
	ctx_t               ctx_s1;
	divst_t             div_s1;
	ctx_t               ctx_d;
	divst_t             div_d;
	logic [15:0]        mask;
	logic [15:0]        sbit;
	logic [15:0]        op_m;
	logic [15:0]        tst;
	logic [15:0]        ngr;
	logic               is_signed;
	logic signed [16:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [33:0] prod;
	logic [31:0]        num;
	logic [31:0]        nmag;
	logic [15:0]        den;
	logic [15:0]        dmag;
	logic               n_neg;
	logic               d_neg;

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_ctx   = ctx_s1;
	assign out_div   = div_s1;

	always_comb begin
		mask = wide ? MASK_WORD : MASK_BYTE;
		sbit = wide ? SIGN_WORD : SIGN_BYTE;
		op_m = operand & mask;
		tst  = op_m & immediate & mask;
		ngr  = (16'd0 - op_m) & mask;

		// shared 17x17 signed multiplier for mul and imul
		if (cmd == CMD_IMUL) begin
			mul_a = wide ? {acc_in[15], acc_in} : {{9{acc_in[7]}}, acc_in[7:0]};
			mul_b = wide ? {operand[15], operand} : {{9{operand[7]}}, operand[7:0]};
		end else begin
			mul_a = wide ? {1'b0, acc_in} : {9'd0, acc_in[7:0]};
			mul_b = wide ? {1'b0, operand} : {9'd0, operand[7:0]};
		end
		prod = mul_a * mul_b;

		// divider operands as magnitudes
		is_signed = (cmd == CMD_IDIV);
		if (wide) begin
			num = {ext_in, acc_in};
			den = operand;
		end else if (is_signed) begin
			num = {{16{acc_in[15]}}, acc_in};
			den = {{8{operand[7]}}, operand[7:0]};
		end else begin
			num = {16'd0, acc_in};
			den = {8'd0, operand[7:0]};
		end
		n_neg = is_signed && num[31];
		d_neg = is_signed && den[15];
		nmag  = n_neg ? (~num + 32'd1) : num;
		dmag  = d_neg ? (~den + 16'd1) : den;

		div_d.w    = nmag;
		div_d.dmag = dmag;

		ctx_d.cmd     = cmd;
		ctx_d.wide    = wide;
		ctx_d.prod    = prod[31:0];
		ctx_d.n_neg   = n_neg;
		ctx_d.d_neg   = d_neg;
		ctx_d.pre_ovf = (nmag[31:16] >= dmag);
		ctx_d.res.acc = acc_in;
		ctx_d.res.ext = ext_in;
		ctx_d.res.opo = 16'd0;
		ctx_d.res.opw = 1'b0;
		ctx_d.res.grp = GRP_NONE;
		ctx_d.res.cf  = 1'b0;
		ctx_d.res.of  = 1'b0;
		ctx_d.res.zf  = 1'b0;
		ctx_d.res.sf  = 1'b0;
		ctx_d.res.pf  = 1'b0;
		ctx_d.res.err = ERR_NONE;

		unique case (cmd)
			CMD_TEST: begin
				ctx_d.res.zf  = (tst == 16'd0);
				ctx_d.res.sf  = |(tst & sbit);
				ctx_d.res.pf  = ~^tst[7:0];
				ctx_d.res.grp = GRP_ALL;
			end
			CMD_UNUSED: begin
				ctx_d.res.err = ERR_BAD_CMD;
			end
			CMD_NOT: begin
				ctx_d.res.opo = ~op_m & mask;
				ctx_d.res.opw = 1'b1;
			end
			CMD_NEG: begin
				ctx_d.res.opo = ngr;
				ctx_d.res.opw = 1'b1;
				ctx_d.res.cf  = (ngr != 16'd0);
				ctx_d.res.of  = (ngr == sbit);
				ctx_d.res.zf  = (ngr == 16'd0);
				ctx_d.res.sf  = |(ngr & sbit);
				ctx_d.res.grp = GRP_COZS;
			end
			CMD_MUL, CMD_IMUL, CMD_DIV, CMD_IDIV: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ctx_s1 <= ctx_d;
			div_s1 <= div_d;
		end
	end

endmodule

// File: hw/rtl/x86g3_div_cell.sv
// x86g3_div_cell: one restoring-division step, one quotient bit per cell
// depends on x86g3_pkg

module x86g3_div_cell import x86g3_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  ctx_t   in_ctx,
	input  divst_t in_div,
	output logic   out_valid,
	input  logic   out_ready,
	output ctx_t   out_ctx,
	output divst_t out_div
);

	logic        valid_q;
	ctx_t        ctx_q;
	divst_t      div_q;
	logic [16:0] trial;
	logic [16:0] diff;
	logic        ge;
	logic [15:0] nrem;
	divst_t      div_d;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_ctx   = ctx_q;
	assign out_div   = div_q;

	always_comb begin
		trial      = in_div.w[31:15];
		diff       = trial - {1'b0, in_div.dmag};
		ge         = (trial >= {1'b0, in_div.dmag});
		nrem       = ge ? diff[15:0] : trial[15:0];
		div_d.w    = {nrem, in_div.w[14:0], ge};
		div_d.dmag = in_div.dmag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ctx_q <= in_ctx;
			div_q <= div_d;
		end
	end

endmodule

// File: hw/rtl/x86g3_finish.sv
// x86g3_finish: mul/imul flags, quotient and remainder sign fix and range check, output register
// depends on x86g3_pkg

module x86g3_finish import x86g3_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  ctx_t   in_ctx,
	input  divst_t in_div,
	output logic   out_valid,
	input  logic   out_ready,
	output res_t   out_res
);

	logic        valid_q;
	res_t        res_q;
	res_t        res_d;
	logic [15:0] qmag;
	logic [15:0] rmag;
	logic [15:0] qv;
	logic [15:0] rv;
	logic        q_neg;
	logic        is_signed;
	logic [16:0] limit;
	logic        ovf;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_comb begin
		qmag      = in_div.w[15:0];
		rmag      = in_div.w[31:16];
		q_neg     = in_ctx.n_neg ^ in_ctx.d_neg;
		qv        = q_neg ? (16'd0 - qmag) : qmag;
		rv        = in_ctx.n_neg ? (16'd0 - rmag) : rmag;
		is_signed = (in_ctx.cmd == CMD_IDIV);
		if (in_ctx.wide) begin
			limit = is_signed ? (q_neg ? 17'd32768 : 17'd32767) : 17'd65535;
		end else begin
			limit = is_signed ? (q_neg ? 17'd128 : 17'd127) : 17'd255;
		end
		ovf = in_ctx.pre_ovf || ({1'b0, qmag} > limit);

		res_d = in_ctx.res;
		unique case (in_ctx.cmd)
			CMD_MUL: begin
				res_d.grp = GRP_CO;
				res_d.acc = in_ctx.prod[15:0];
				if (in_ctx.wide) begin
					res_d.ext = in_ctx.prod[31:16];
					res_d.cf  = |in_ctx.prod[31:16];
				end else begin
					res_d.cf  = |in_ctx.prod[15:8];
				end
				res_d.of = res_d.cf;
			end
			CMD_IMUL: begin
				res_d.grp = GRP_CO;
				res_d.acc = in_ctx.prod[15:0];
				if (in_ctx.wide) begin
					res_d.ext = in_ctx.prod[31:16];
					res_d.cf  = !((&in_ctx.prod[31:15]) || !(|in_ctx.prod[31:15]));
				end else begin
					res_d.cf  = !((&in_ctx.prod[15:7]) || !(|in_ctx.prod[15:7]));
				end
				res_d.of = res_d.cf;
			end
			CMD_DIV, CMD_IDIV: begin
				if (ovf) begin
					res_d.err = ERR_DIVIDE;
				end else if (in_ctx.wide) begin
					res_d.acc = qv;
					res_d.ext = rv;
				end else begin
					res_d.acc = {rv[7:0], qv[7:0]};
				end
			end
			CMD_TEST, CMD_UNUSED, CMD_NOT, CMD_NEG: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			res_q <= res_d;
		end
	end

endmodule

// File: hw/rtl/x86_group3_muldiv_unit_core.sv
// x86_group3_muldiv_unit_core: top level of the x86 group-3 mul/div unit
// depends on x86g3_pkg, x86g3_front, x86g3_div_cell, x86g3_finish
//
// channel  ports    fields (lowest bit up)
// in       s_axis   tuser: cmd[2:0] wide[3]
//                   tdata: operand[15:0] immediate[31:16] acc_in[47:32] ext_in[63:48]
// out      m_axis   tdata: acc_out ext_out operand_out operand_write flag_group
//                          carry overflow zero sign parity error, zero padded
//
// one transaction per cycle sustained while m_axis_tready stays high; the pipeline is the front stage,
// one cell per quotient bit (16), and the output register
// every stage has its own valid and takes new data whenever it is empty or
// its neighbor downstream takes its contents, so bubbles close up under stall
// arst_n clears all valid bits; payload registers are not reset

module x86_group3_muldiv_unit_core import x86g3_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // operand, immediate, acc_in, ext_in
	input  logic [IN_USER_W-1:0]  s_axis_tuser,  // cmd, wide
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata   // acc_out .. error, see table above
);

	logic             stg_valid [0:DIV_STEPS];
	logic             stg_ready [0:DIV_STEPS];
	ctx_t             stg_ctx   [0:DIV_STEPS];
	divst_t           stg_div   [0:DIV_STEPS];
	res_t             res;

	x86g3_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.cmd       (cmd_t'(s_axis_tuser[2:0])),
		.wide      (s_axis_tuser[3]),
		.operand   (s_axis_tdata[15:0]),
		.immediate (s_axis_tdata[31:16]),
		.acc_in    (s_axis_tdata[47:32]),
		.ext_in    (s_axis_tdata[63:48]),
		.out_valid (stg_valid[0]),
		.out_ready (stg_ready[0]),
		.out_ctx   (stg_ctx[0]),
		.out_div   (stg_div[0])
	);

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
		x86g3_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (stg_valid[i]),
			.in_ready  (stg_ready[i]),
			.in_ctx    (stg_ctx[i]),
			.in_div    (stg_div[i]),
			.out_valid (stg_valid[i+1]),
			.out_ready (stg_ready[i+1]),
			.out_ctx   (stg_ctx[i+1]),
			.out_div   (stg_div[i+1])
		);
	end

	x86g3_finish u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (stg_valid[DIV_STEPS]),
		.in_ready  (stg_ready[DIV_STEPS]),
		.in_ctx    (stg_ctx[DIV_STEPS]),
		.in_div    (stg_div[DIV_STEPS]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {6'd0, res.err, res.pf, res.sf, res.zf, res.of, res.cf,
		res.grp, res.opw, res.opo, res.ext, res.acc};

endmodule

// File: sim/testbench.sv
// testbench for x86_group3_muldiv_unit_core: directed and random group-3 operations
// streamed through the unit under random stalls, each result checked against a local predictor
// depends on x86g3_pkg and the rtl of the unit
`timescale 1ns / 1ps

module testbench;
	import x86g3_pkg::*;

	localparam int RANDOM_ITEMS = 1850;
	localparam int IDLE_PCT     = 12;
	localparam int QUIET_LO     = 700;
	localparam int QUIET_HI     = 1000;
	localparam int HOLD_AT      = 400;
	localparam int HOLD_CYCLES  = 80;
	localparam int PAUSE_AT     = 1250;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		cmd_t        cmd;
		logic        wide;
		logic [15:0] operand;
		logic [15:0] immediate;
		logic [15:0] acc_in;
		logic [15:0] ext_in;
	} grp3_item_t;

	// same layout as m_axis_tdata, highest bits first
	typedef struct packed {
		logic [5:0]  pad;
		logic [1:0]  err;
		logic        pf;
		logic        sf;
		logic        zf;
		logic        of;
		logic        cf;
		logic [1:0]  grp;
		logic        opw;
		logic [15:0] opo;
		logic [15:0] ext;
		logic [15:0] acc;
	} grp3_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // operand, immediate, acc_in, ext_in
	logic [IN_USER_W-1:0]  s_axis_tuser = '0;  // cmd, wide
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;       // acc_out .. error, zero padded

	grp3_item_t   pending_items[$];
	grp3_result_t expected_results[$];
	grp3_item_t   drive_item;
	int           sent_count = 0;
	int           recv_count = 0;
	int           mismatch_count = 0;
	int           divide_errors = 0;
	int           cmd_seen[8];
	int           hold_left = 0;
	logic         hold_done = 1'b0;
	logic         sender_quiet;
	logic         receiver_quiet;

	x86_group3_muldiv_unit_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic grp3_result_t predict_group3(input grp3_item_t it);
		grp3_result_t r;
		logic [15:0]  mask;
		logic [15:0]  sbit;
		logic [15:0]  op;
		logic [15:0]  imm;
		logic [15:0]  v;
		logic [31:0]  num;
		logic [31:0]  quo;
		logic [31:0]  rem;
		longint       sp;
		longint       sn;
		longint       sd;
		longint       sq;
		longint       sm;
		longint       qlo;
		longint       qhi;
		r = '0;
		mask = it.wide ? MASK_WORD : MASK_BYTE;
		sbit = it.wide ? SIGN_WORD : SIGN_BYTE;
		op = it.operand & mask;
		imm = it.immediate & mask;
		r.acc = it.acc_in;
		r.ext = it.ext_in;
		case (it.cmd)
			CMD_TEST: begin
				v = op & imm;
				r.zf = (v == 16'd0);
				r.sf = ((v & sbit) != 16'd0);
				r.pf = ~^v[7:0];
				r.grp = GRP_ALL;
			end
			CMD_UNUSED: begin
				r.err = ERR_BAD_CMD;
			end
			CMD_NOT: begin
				r.opo = ~op & mask;
				r.opw = 1'b1;
			end
			CMD_NEG: begin
				v = (16'd0 - op) & mask;
				r.opo = v;
				r.opw = 1'b1;
				r.cf = (v != 16'd0);
				r.of = (v == sbit);
				r.zf = (v == 16'd0);
				r.sf = ((v & sbit) != 16'd0);
				r.grp = GRP_COZS;
			end
			CMD_MUL: begin
				if (it.wide) begin
					num = {16'd0, it.acc_in} * {16'd0, op};
					r.acc = num[15:0];
					r.ext = num[31:16];
					r.cf = (num[31:16] != 16'd0);
				end else begin
					r.acc = {8'd0, it.acc_in[7:0]} * {8'd0, op[7:0]};
					r.cf = (r.acc[15:8] != 8'd0);
				end
				r.of = r.cf;
				r.grp = GRP_CO;
			end
			CMD_IMUL: begin
				if (it.wide) begin
					sp = longint'($signed(it.acc_in)) * longint'($signed(op));
					r.acc = sp[15:0];
					r.ext = sp[31:16];
					r.cf = (sp < -32768 || sp > 32767);
				end else begin
					sp = longint'($signed(it.acc_in[7:0])) * longint'($signed(op[7:0]));
					r.acc = sp[15:0];
					r.cf = (sp < -128 || sp > 127);
				end
				r.of = r.cf;
				r.grp = GRP_CO;
			end
			CMD_DIV: begin
				if (op == 16'd0) begin
					r.err = ERR_DIVIDE;
				end else if (it.wide) begin
					num = {it.ext_in, it.acc_in};
					quo = num / {16'd0, op};
					rem = num % {16'd0, op};
					if (quo > 32'h0000_FFFF) begin
						r.err = ERR_DIVIDE;
					end else begin
						r.acc = quo[15:0];
						r.ext = rem[15:0];
					end
				end else begin
					quo = {16'd0, it.acc_in} / {16'd0, op};
					rem = {16'd0, it.acc_in} % {16'd0, op};
					if (quo > 32'h0000_00FF) begin
						r.err = ERR_DIVIDE;
					end else begin
						r.acc = {rem[7:0], quo[7:0]};
					end
				end
			end
			default: begin
				if (op == 16'd0) begin
					r.err = ERR_DIVIDE;
				end else begin
					if (it.wide) begin
						sn = longint'($signed({it.ext_in, it.acc_in}));
						sd = longint'($signed(op));
						qlo = -32768;
						qhi = 32767;
					end else begin
						sn = longint'($signed(it.acc_in));
						sd = longint'($signed(op[7:0]));
						qlo = -128;
						qhi = 127;
					end
					sq = sn / sd;
					sm = sn % sd;
					if (sq < qlo || sq > qhi) begin
						r.err = ERR_DIVIDE;
					end else if (it.wide) begin
						r.acc = sq[15:0];
						r.ext = sm[15:0];
					end else begin
						r.acc = {sm[7:0], sq[7:0]};
					end
				end
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("mismatch at result %0d, %s: got %h expected %h", recv_count, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_result(input grp3_result_t got, input grp3_result_t want);
		if (got.acc !== want.acc) report_mismatch("acc_out", got.acc, want.acc);
		if (got.ext !== want.ext) report_mismatch("ext_out", got.ext, want.ext);
		if (got.opo !== want.opo) report_mismatch("operand_out", got.opo, want.opo);
		if (got.opw !== want.opw) report_mismatch("operand_write", got.opw, want.opw);
		if (got.grp !== want.grp) report_mismatch("flag_group", got.grp, want.grp);
		if (got.cf !== want.cf) report_mismatch("carry", got.cf, want.cf);
		if (got.of !== want.of) report_mismatch("overflow", got.of, want.of);
		if (got.zf !== want.zf) report_mismatch("zero", got.zf, want.zf);
		if (got.sf !== want.sf) report_mismatch("sign", got.sf, want.sf);
		if (got.pf !== want.pf) report_mismatch("parity", got.pf, want.pf);
		if (got.err !== want.err) report_mismatch("error", got.err, want.err);
		if (got.pad !== 6'd0) report_mismatch("padding", got.pad, 16'd0);
	endtask

	task automatic add_item(input cmd_t cmd, input logic wide, input logic [15:0] op,
			input logic [15:0] imm, input logic [15:0] ax, input logic [15:0] dx);
		grp3_item_t it;
		it.cmd = cmd;
		it.wide = wide;
		it.operand = op;
		it.immediate = imm;
		it.acc_in = ax;
		it.ext_in = dx;
		pending_items.push_back(it);
	endtask

	task automatic build_directed();
		// byte test ignores the upper bits and gives zero
		add_item(CMD_TEST, 1'b0, 16'hABFF, 16'h5500, 16'h1234, 16'h5678);
		add_item(CMD_TEST, 1'b1, 16'h8000, 16'hFFFF, 16'hFFFF, 16'h0000);
		add_item(CMD_TEST, 1'b0, 16'h0003, 16'h00FF, 16'h0000, 16'hFFFF);
		add_item(CMD_UNUSED, 1'b1, 16'hFFFF, 16'hFFFF, 16'hA5A5, 16'h5A5A);
		add_item(CMD_UNUSED, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		add_item(CMD_NOT, 1'b0, 16'h1200, 16'h0000, 16'h0000, 16'h0000);
		add_item(CMD_NOT, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		// neg of the most negative value, of zero and of one
		add_item(CMD_NEG, 1'b0, 16'hFF80, 16'h0000, 16'h0000, 16'h0000);
		add_item(CMD_NEG, 1'b1, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
		add_item(CMD_NEG, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		add_item(CMD_NEG, 1'b0, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
		add_item(CMD_MUL, 1'b0, 16'h00FF, 16'h0000, 16'h00FF, 16'h1111);
		add_item(CMD_MUL, 1'b1, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h1111);
		add_item(CMD_MUL, 1'b0, 16'hFF03, 16'h0000, 16'hAB02, 16'h0000);
		add_item(CMD_IMUL, 1'b0, 16'h0080, 16'h0000, 16'h0080, 16'h0000);
		add_item(CMD_IMUL, 1'b0, 16'h0001, 16'h0000, 16'h0080, 16'h0000);
		add_item(CMD_IMUL, 1'b1, 16'h8000, 16'h0000, 16'h8000, 16'h0000);
		add_item(CMD_IMUL, 1'b1, 16'h8000, 16'h0000, 16'hFFFF, 16'h0000);
		// division by zero, quotient overflow, and in-range div and idiv
		add_item(CMD_DIV, 1'b0, 16'hFF00, 16'h0000, 16'h1234, 16'h5678);
		add_item(CMD_DIV, 1'b1, 16'h0000, 16'h0000, 16'h1234, 16'h5678);
		add_item(CMD_DIV, 1'b0, 16'h0001, 16'h0000, 16'h0100, 16'h0000);
		add_item(CMD_DIV, 1'b1, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
		add_item(CMD_DIV, 1'b1, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFE);
		add_item(CMD_IDIV, 1'b0, 16'h00FF, 16'h0000, 16'hFF80, 16'h0000);
		add_item(CMD_IDIV, 1'b0, 16'h0002, 16'h0000, 16'hFFF9, 16'h0000);
		add_item(CMD_IDIV, 1'b1, 16'hFFFF, 16'h0000, 16'h0000, 16'h8000);
		add_item(CMD_IDIV, 1'b1, 16'h0002, 16'h0000, 16'hFFF9, 16'hFFFF);
	endtask

	task automatic build_random();
		cmd_t        cmd;
		logic        wide;
		logic [15:0] op;
		logic [15:0] imm;
		logic [15:0] ax;
		logic [15:0] dx;
		logic        shaped;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			cmd = cmd_t'($urandom_range(0, 7));
			wide = 1'($urandom_range(0, 1));
			op = 16'($urandom);
			imm = 16'($urandom);
			ax = 16'($urandom);
			dx = 16'($urandom);
			shaped = ($urandom_range(0, 99) >= 15);
			if (shaped) begin
				case (cmd)
					CMD_TEST: begin
						if ($urandom_range(0, 2) == 0) imm = imm & ~op;
					end
					CMD_MUL, CMD_IMUL: begin
						if ($urandom_range(0, 1) == 0) begin
							ax = {{12{ax[3]}}, ax[3:0]};
							op = {{12{op[3]}}, op[3:0]};
						end
					end
					CMD_DIV: begin
						if (wide) begin
							if (op == 16'd0) op = 16'd1;
							dx = dx % op;
						end else begin
							if (op[7:0] == 8'd0) op[0] = 1'b1;
							ax[15:8] = ax[15:8] % op[7:0];
						end
					end
					CMD_IDIV: begin
						if (wide) begin
							if (op == 16'd0) op = 16'd1;
							dx = {16{ax[15]}};
						end else begin
							if (op[7:0] == 8'd0) op[0] = 1'b1;
							ax[15:8] = {8{ax[7]}};
						end
					end
					default: begin
					end
				endcase
			end
			add_item(cmd, wide, op, imm, ax, dx);
		end
	endtask

	assign sender_quiet = (sent_count >= QUIET_LO && sent_count < QUIET_HI);
	assign receiver_quiet = (recv_count >= QUIET_LO && recv_count < QUIET_HI);

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_results.push_back(predict_group3(drive_item));
				cmd_seen[drive_item.cmd]++;
				sent_count++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_items.size() != 0
						&& (sender_quiet || $urandom_range(0, 99) >= IDLE_PCT)
						&& !(sent_count == PAUSE_AT && expected_results.size() != 0)) begin
					drive_item = pending_items.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {drive_item.ext_in, drive_item.acc_in,
						drive_item.immediate, drive_item.operand};
					s_axis_tuser <= {drive_item.wide, drive_item.cmd};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, once
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && sent_count >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected transaction", m_axis_tdata[15:0], 16'd0);
				end else begin
					if (expected_results[0].err == ERR_DIVIDE) divide_errors++;
					check_result(grp3_result_t'(m_axis_tdata), expected_results.pop_front());
				end
				recv_count++;
			end
			if (hold_left != 0) begin
				m_axis_tready <= 1'b0;
			end else if (receiver_quiet) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	initial begin
		build_directed();
		build_random();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_items.size() != 0 || s_axis_tvalid) @(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d transactions in, %0d out: test %0d, unused %0d, not %0d, neg %0d,",
			sent_count, recv_count, cmd_seen[CMD_TEST], cmd_seen[CMD_UNUSED],
			cmd_seen[CMD_NOT], cmd_seen[CMD_NEG]);
		$display("mul %0d, imul %0d, div %0d, idiv %0d, divide errors %0d, mismatches %0d",
			cmd_seen[CMD_MUL], cmd_seen[CMD_IMUL], cmd_seen[CMD_DIV], cmd_seen[CMD_IDIV],
			divide_errors, mismatch_count);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d results outstanding", expected_results.size());
		$display("FAIL");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/x86g3_pkg.sv
hw/rtl/x86g3_front.sv
hw/rtl/x86g3_div_cell.sv
hw/rtl/x86g3_finish.sv
hw/rtl/x86_group3_muldiv_unit_core.sv
sim/testbench.sv
